>>> rtl/core/trd_pkg.sv
// shared types and constants of the triangle rasterizer with depth test
`timescale 1ns / 1ps
package trd_pkg;

    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 128;

    localparam int CW    = 32;   // screen coordinate width, 2^-15 pixel units
    localparam int EW    = 64;   // edge function width
    localparam int ACCW  = 82;   // dividend width
    localparam int QW    = 16;   // quotient width
    localparam int PXW   = 10;   // pixel counter width
    localparam int DIMW  = 8;    // screen dimension width
    localparam int FRAGW = 64;
    localparam int STW   = FRAGW + QW;

    localparam int SUBPIX_SHIFT = 15;
    localparam logic signed [CW-1:0] NDC_BIAS = 32'sd16384;

    localparam logic [1:0] OP_DRAW  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [DIMW-1:0]  RESET_DIM   = 8'd128;
    localparam logic [QW-1:0]    DEPTH_CLEAR = '0;
    localparam logic [FRAGW-1:0] FRAG_CLEAR  = '1;
    localparam logic [QW-1:0]    TRI_NONE    = '1;

    typedef struct packed {
        logic            start;
        logic [ACCW-1:0] num;
        logic [EW-1:0]   den;
    } div_req_t;

    typedef struct packed {
        logic          busy;
        logic          done;
        logic [QW-1:0] quo;
    } div_rsp_t;

endpackage

>>> rtl/core/triangle_raster_depth_test.sv
// top level: sequencer for triangle raster, depth test, read and clear
// read item: result word registered once the output is free; clear item: rewrites all MAX_WIDTH*MAX_HEIGHT words
// draw item: setup, then a walk over every pixel of the clipped box; covered pixels take a depth
// division and test, and written pixels three weight divisions, all on the shared
// multiplier and the 16-step divider; one item at a time
// reset (synchronous, active low) runs a clearing pass over all MAX_WIDTH*MAX_HEIGHT words
// during which no item is accepted; configuration writes are taken at all times outside reset
`timescale 1ns / 1ps
module triangle_raster_depth_test
    import trd_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [DIMW-1:0]     cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_op,
    input  logic [15:0]         s_tri_index,
    input  logic signed [15:0]  s_vert0_x,
    input  logic signed [15:0]  s_vert0_y,
    input  logic [15:0]         s_vert0_invz,
    input  logic signed [15:0]  s_vert1_x,
    input  logic signed [15:0]  s_vert1_y,
    input  logic [15:0]         s_vert1_invz,
    input  logic signed [15:0]  s_vert2_x,
    input  logic signed [15:0]  s_vert2_y,
    input  logic [15:0]         s_vert2_invz,
    input  logic [13:0]         s_pixel_addr,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [15:0]         m_frag_tri,
    output logic [15:0]         m_weight_v0,
    output logic [15:0]         m_weight_v1,
    output logic [15:0]         m_weight_v2,
    output logic [15:0]         m_pixel_depth,
    output logic                m_covered
);

    localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW         = $clog2(STORE_SIZE);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RDATA, S_MAP, S_BOX, S_EDGE, S_CHECK, S_PIX,
        S_MAC, S_DDIV, S_DWAIT, S_DTEST, S_WDIV, S_WWAIT, S_WRITE
    } state_t;

    state_t state_reg;

    logic [DIMW-1:0] scr_w_reg, scr_h_reg;
    logic [DIMW-1:0] eff_w, eff_h;
    logic [DIMW-1:0] w_reg, h_reg;

    logic signed [CW-1:0] vx_reg [3];
    logic signed [CW-1:0] vy_reg [3];
    logic [QW-1:0]        vz_reg [3];
    logic [15:0]          tri_reg;

    logic [3:0]           mstep_reg;
    logic [3:0]           prev;
    logic signed [EW-1:0] tmp_reg;
    logic signed [EW-1:0] area_reg;
    logic signed [EW-1:0] e_reg   [3];   // edges v0v1, v1v2, v2v0
    logic signed [EW-1:0] row_reg [3];
    logic [PXW-1:0]       x0_reg, x1_reg, y0_reg, y1_reg, px_reg, py_reg;
    logic                 empty_reg;
    logic [AW-1:0]        addr_reg, rowbase_reg, clr_reg;
    logic [ACCW-1:0]      acc_reg;
    logic [QW-1:0]        d_reg;
    logic [QW-1:0]        wt_reg [3];
    logic [1:0]           k_reg;
    logic                 in_range_reg;

    logic                 m_valid_reg;
    logic [15:0]          m_tri_reg, m_w0_reg, m_w1_reg, m_w2_reg, m_depth_reg;
    logic                 m_cov_reg;

    // multiplier and divider
    logic signed [CW-1:0]   mul_a, mul_b;
    logic signed [2*CW-1:0] mul_p;
    div_req_t               div_req;
    div_rsp_t               div_rsp;

    // store ports
    logic           st_wr_en, st_rd_en;
    logic [AW-1:0]  st_wr_addr, st_rd_addr;
    logic [STW-1:0] st_wr_data, st_rd_data;

    logic           accept;
    logic [31:0]    pa_ext;
    logic           pa_in_range;

    logic signed [CW-1:0] dx [3];
    logic signed [CW-1:0] dy [3];
    logic signed [EW-1:0] ix [3];
    logic signed [EW-1:0] iy [3];
    logic signed [EW-1:0] dx64, dy64;
    logic signed [CW-1:0] mnx, mxx, mny, mxy;
    logic signed [CW-1:0] x0c, x1c, y0c, y1c, wm1, hm1;
    logic                 box_empty;
    logic signed [CW-1:0] ax, ay, bx, by, ptx, pty, sx0, sy0;
    logic                 cov;
    logic                 skip;
    logic                 adv_go;
    logic                 last_x, last_y;
    logic [1:0]           esel;
    logic [ACCW-1:0]      esel_ext;

    assign eff_w = (32'(scr_w_reg) > MAX_WIDTH)  ? DIMW'(MAX_WIDTH)  : scr_w_reg;
    assign eff_h = (32'(scr_h_reg) > MAX_HEIGHT) ? DIMW'(MAX_HEIGHT) : scr_h_reg;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;

    assign pa_ext      = 32'(s_pixel_addr);
    assign pa_in_range = pa_ext < 32'(STORE_SIZE);

    // edge deltas and per-pixel increments
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            dx[j] = vx_reg[(j + 1) % 3] - vx_reg[j];
            dy[j] = vy_reg[(j + 1) % 3] - vy_reg[j];
            dx64  = EW'(dx[j]);
            dy64  = EW'(dy[j]);
            ix[j] = -(dy64 <<< SUBPIX_SHIFT);
            iy[j] = dx64 <<< SUBPIX_SHIFT;
        end
    end

    // bounding box clipped to the screen
    always_comb begin
        mnx = vx_reg[0]; mxx = vx_reg[0];
        mny = vy_reg[0]; mxy = vy_reg[0];
        for (int j = 1; j < 3; j++) begin
            if (vx_reg[j] < mnx) mnx = vx_reg[j];
            if (vx_reg[j] > mxx) mxx = vx_reg[j];
            if (vy_reg[j] < mny) mny = vy_reg[j];
            if (vy_reg[j] > mxy) mxy = vy_reg[j];
        end
        wm1 = CW'(w_reg) - 32'sd1;
        hm1 = CW'(h_reg) - 32'sd1;
        x0c = (mnx < 0) ? '0 : (mnx >>> SUBPIX_SHIFT);
        y0c = (mny < 0) ? '0 : (mny >>> SUBPIX_SHIFT);
        x1c = mxx >>> SUBPIX_SHIFT;
        y1c = mxy >>> SUBPIX_SHIFT;
        if (x1c > wm1) x1c = wm1;
        if (y1c > hm1) y1c = hm1;
        box_empty = (mxx < 0) || (mxy < 0) || (x0c > x1c) || (y0c > y1c);
    end

    assign sx0 = signed'(CW'({x0_reg, 15'b0}));
    assign sy0 = signed'(CW'({y0_reg, 15'b0}));

    // operand pair for the edge setup program
    always_comb begin
        ax = vx_reg[0]; ay = vy_reg[0]; bx = vx_reg[1]; by = vy_reg[1];
        ptx = vx_reg[2]; pty = vy_reg[2];
        case (mstep_reg[3:1])
            3'd1: begin
                ptx = sx0; pty = sy0;
            end
            3'd2: begin
                ax = vx_reg[1]; ay = vy_reg[1]; bx = vx_reg[2]; by = vy_reg[2];
                ptx = sx0; pty = sy0;
            end
            3'd3: begin
                ax = vx_reg[2]; ay = vy_reg[2]; bx = vx_reg[0]; by = vy_reg[0];
                ptx = sx0; pty = sy0;
            end
            default: begin
                ax = vx_reg[0]; ay = vy_reg[0]; bx = vx_reg[1]; by = vy_reg[1];
            end
        endcase
    end

    // edge used by the mac step or weight division: v1v2, v2v0, v0v1
    always_comb begin
        if (state_reg == S_MAC) begin
            case (mstep_reg[2:1])
                2'd0:    esel = 2'd1;
                2'd1:    esel = 2'd2;
                default: esel = 2'd0;
            endcase
        end else begin
            case (k_reg)
                2'd0:    esel = 2'd1;
                2'd1:    esel = 2'd2;
                default: esel = 2'd0;
            endcase
        end
        esel_ext = ACCW'(unsigned'(e_reg[esel]));
    end

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MAP: begin
                if (mstep_reg < 4'd3) begin
                    mul_a = vx_reg[mstep_reg[1:0]] + NDC_BIAS;
                    mul_b = CW'(w_reg);
                end else if (mstep_reg < 4'd6) begin
                    mul_a = vy_reg[2'(mstep_reg - 4'd3)] + NDC_BIAS;
                    mul_b = CW'(h_reg);
                end
            end
            S_EDGE: begin
                if (mstep_reg == 4'd8) begin
                    mul_a = CW'(y0_reg);
                    mul_b = CW'(w_reg);
                end else if (!mstep_reg[0]) begin
                    mul_a = bx - ax;
                    mul_b = pty - ay;
                end else begin
                    mul_a = by - ay;
                    mul_b = ptx - ax;
                end
            end
            S_MAC: begin
                if (mstep_reg < 4'd6) begin
                    // low 31 bits, then the next 31 bits of the edge value
                    mul_a = mstep_reg[0] ? CW'(esel_ext[ACCW-1:31] & 51'h7FFFFFFF)
                                         : CW'(esel_ext[30:0]);
                    mul_b = CW'(vz_reg[mstep_reg[2:1]]);
                end
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prev = mstep_reg - 4'd1;

    // divider request
    always_comb begin
        div_req.start = (state_reg == S_DDIV) || (state_reg == S_WDIV);
        div_req.den   = unsigned'(area_reg);
        div_req.num   = (state_reg == S_DDIV) ? acc_reg : ((esel_ext << 16) - esel_ext);
    end

    assign cov    = !e_reg[0][EW-1] && !e_reg[1][EW-1] && !e_reg[2][EW-1];
    assign skip   = st_rd_data[QW-1:0] > d_reg;
    assign last_x = (px_reg == x1_reg);
    assign last_y = (py_reg == y1_reg);
    assign adv_go = ((state_reg == S_PIX) && !cov) ||
                    ((state_reg == S_DTEST) && skip) ||
                    (state_reg == S_WRITE);

    // store ports
    assign st_wr_en   = (state_reg == S_CLEAR) || (state_reg == S_WRITE);
    assign st_wr_addr = (state_reg == S_CLEAR) ? clr_reg : addr_reg;
    assign st_wr_data = (state_reg == S_CLEAR) ? {FRAG_CLEAR, DEPTH_CLEAR}
                      : {tri_reg, wt_reg[0], wt_reg[1], wt_reg[2], d_reg};
    assign st_rd_en   = (accept && (s_op == OP_READ)) || ((state_reg == S_PIX) && cov);
    assign st_rd_addr = (state_reg == S_IDLE) ? pa_ext[AW-1:0] : addr_reg;

    trd_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    trd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    trd_store #(
        .SIZE (STORE_SIZE),
        .AW   (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scr_w_reg <= RESET_DIM;
            scr_h_reg <= RESET_DIM;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_WIDTH) begin
                scr_w_reg <= cfg_data;
            end else begin
                scr_h_reg <= cfg_data;
            end
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            mstep_reg   <= '0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // the read state reloads the result word itself
            if (m_valid_reg && m_ready && (state_reg != S_RDATA)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    if (clr_reg == AW'(STORE_SIZE - 1)) begin
                        state_reg <= S_IDLE;
                    end else begin
                        clr_reg <= clr_reg + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        case (s_op)
                            OP_DRAW: begin
                                vx_reg[0] <= CW'(s_vert0_x);
                                vy_reg[0] <= CW'(s_vert0_y);
                                vz_reg[0] <= s_vert0_invz;
                                vx_reg[1] <= CW'(s_vert1_x);
                                vy_reg[1] <= CW'(s_vert1_y);
                                vz_reg[1] <= s_vert1_invz;
                                vx_reg[2] <= CW'(s_vert2_x);
                                vy_reg[2] <= CW'(s_vert2_y);
                                vz_reg[2] <= s_vert2_invz;
                                tri_reg   <= s_tri_index;
                                w_reg     <= eff_w;
                                h_reg     <= eff_h;
                                mstep_reg <= '0;
                                if (eff_w != '0 && eff_h != '0) begin
                                    state_reg <= S_MAP;
                                end
                            end
                            OP_READ: begin
                                in_range_reg <= pa_in_range;
                                state_reg    <= S_RDATA;
                            end
                            OP_CLEAR: begin
                                clr_reg   <= '0;
                                state_reg <= S_CLEAR;
                            end
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_RDATA: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        if (in_range_reg) begin
                            m_tri_reg   <= st_rd_data[STW-1:STW-16];
                            m_w0_reg    <= st_rd_data[STW-17:STW-32];
                            m_w1_reg    <= st_rd_data[STW-33:STW-48];
                            m_w2_reg    <= st_rd_data[STW-49:STW-64];
                            m_depth_reg <= st_rd_data[QW-1:0];
                            m_cov_reg   <= st_rd_data[STW-1:STW-16] != TRI_NONE;
                        end else begin
                            m_tri_reg   <= TRI_NONE;
                            m_w0_reg    <= '1;
                            m_w1_reg    <= '1;
                            m_w2_reg    <= '1;
                            m_depth_reg <= DEPTH_CLEAR;
                            m_cov_reg   <= 1'b0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_MAP: begin
                    if (mstep_reg != '0) begin
                        if (prev < 4'd3) begin
                            vx_reg[prev[1:0]] <= mul_p[CW-1:0];
                        end else begin
                            vy_reg[2'(prev - 4'd3)] <= mul_p[CW-1:0];
                        end
                    end
                    if (mstep_reg == 4'd6) begin
                        state_reg <= S_BOX;
                    end else begin
                        mstep_reg <= mstep_reg + 4'd1;
                    end
                end
                S_BOX: begin
                    x0_reg    <= PXW'(x0c);
                    y0_reg    <= PXW'(y0c);
                    x1_reg    <= PXW'(x1c);
                    y1_reg    <= PXW'(y1c);
                    empty_reg <= box_empty;
                    mstep_reg <= '0;
                    state_reg <= S_EDGE;
                end
                S_EDGE: begin
                    if (mstep_reg != '0) begin
                        if (prev == 4'd8) begin
                            rowbase_reg <= mul_p[AW-1:0];
                            addr_reg    <= AW'(mul_p[AW-1:0] + AW'(x0_reg));
                        end else if (!prev[0]) begin
                            tmp_reg <= mul_p;
                        end else if (prev[3:1] == 3'd0) begin
                            area_reg <= tmp_reg - mul_p;
                        end else begin
                            e_reg[2'(prev[3:1] - 3'd1)]   <= tmp_reg - mul_p;
                            row_reg[2'(prev[3:1] - 3'd1)] <= tmp_reg - mul_p;
                        end
                    end
                    if (mstep_reg == 4'd9) begin
                        state_reg <= S_CHECK;
                    end else begin
                        mstep_reg <= mstep_reg + 4'd1;
                    end
                end
                S_CHECK: begin
                    px_reg <= x0_reg;
                    py_reg <= y0_reg;
                    if (area_reg <= 0 || empty_reg) begin
                        state_reg <= S_IDLE;
                    end else begin
                        state_reg <= S_PIX;
                    end
                end
                S_PIX: begin
                    if (cov) begin
                        acc_reg   <= '0;
                        mstep_reg <= '0;
                        state_reg <= S_MAC;
                    end
                end
                S_MAC: begin
                    if (mstep_reg != '0) begin
                        if (!prev[0]) begin
                            acc_reg <= acc_reg + ACCW'(unsigned'(mul_p));
                        end else begin
                            acc_reg <= acc_reg + (ACCW'(unsigned'(mul_p)) << 31);
                        end
                    end
                    if (mstep_reg == 4'd6) begin
                        state_reg <= S_DDIV;
                    end else begin
                        mstep_reg <= mstep_reg + 4'd1;
                    end
                end
                S_DDIV: state_reg <= S_DWAIT;
                S_DWAIT: begin
                    if (div_rsp.done) begin
                        d_reg     <= div_rsp.quo;
                        state_reg <= S_DTEST;
                    end
                end
                S_DTEST: begin
                    k_reg <= '0;
                    if (!skip) begin
                        state_reg <= S_WDIV;
                    end
                end
                S_WDIV: state_reg <= S_WWAIT;
                S_WWAIT: begin
                    if (div_rsp.done) begin
                        wt_reg[k_reg] <= div_rsp.quo;
                        if (k_reg == 2'd2) begin
                            state_reg <= S_WRITE;
                        end else begin
                            k_reg     <= k_reg + 2'd1;
                            state_reg <= S_WDIV;
                        end
                    end
                end
                // the pixel step below picks the next state
                S_WRITE: begin
                end
                default: state_reg <= S_IDLE;
            endcase

            // step to the next pixel of the box
            if (adv_go) begin
                if (last_x) begin
                    if (last_y) begin
                        state_reg <= S_IDLE;
                    end else begin
                        py_reg      <= py_reg + 1'b1;
                        px_reg      <= x0_reg;
                        rowbase_reg <= AW'(32'(rowbase_reg) + 32'(w_reg));
                        addr_reg    <= AW'(32'(rowbase_reg) + 32'(w_reg) + 32'(x0_reg));
                        for (int j = 0; j < 3; j++) begin
                            row_reg[j] <= row_reg[j] + iy[j];
                            e_reg[j]   <= row_reg[j] + iy[j];
                        end
                        state_reg <= S_PIX;
                    end
                end else begin
                    px_reg   <= px_reg + 1'b1;
                    addr_reg <= addr_reg + 1'b1;
                    for (int j = 0; j < 3; j++) begin
                        e_reg[j] <= e_reg[j] + ix[j];
                    end
                    state_reg <= S_PIX;
                end
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_frag_tri    = m_tri_reg;
    assign m_weight_v0   = m_w0_reg;
    assign m_weight_v1   = m_w1_reg;
    assign m_weight_v2   = m_w2_reg;
    assign m_pixel_depth = m_depth_reg;
    assign m_covered     = m_cov_reg;

`ifndef ASSERT_OFF
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> (state_reg == S_CLEAR))
        else $error("reset did not start the clearing pass");

    a_result_from_read: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_RDATA))
        else $error("result word raised outside a read");

    a_depth_keep: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WRITE) |-> (st_rd_data[QW-1:0] <= d_reg))
        else $error("fragment written against a nearer stored depth");

    a_pixel_in_box: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PIX) |-> (px_reg <= x1_reg && py_reg <= y1_reg))
        else $error("pixel walk left the bounding box");
`endif

endmodule

>>> rtl/core/trd_mul.sv
// shared signed multiplier with registered product
`timescale 1ns / 1ps
module trd_mul
    import trd_pkg::*;
(
    input  logic                   aclk,
    input  logic signed [CW-1:0]   a,
    input  logic signed [CW-1:0]   b,
    output logic signed [2*CW-1:0] p
);

    logic signed [2*CW-1:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

>>> rtl/core/trd_div.sv
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module trd_div
    import trd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [ACCW-1:0] rem_reg;
    logic [ACCW-1:0] den_reg;
    logic [QW-1:0]   quo_reg;
    logic [3:0]      cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic            ge;

    assign ge = rem_reg >= den_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                rem_reg  <= req.num;
                // divisor aligned to the top quotient bit
                den_reg  <= ACCW'(req.den) << (QW - 1);
                quo_reg  <= '0;
                cnt_reg  <= 4'(QW - 1);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (ge) begin
                    rem_reg <= rem_reg - den_reg;
                end
                quo_reg <= {quo_reg[QW-2:0], ge};
                den_reg <= den_reg >> 1;
                if (cnt_reg == 4'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 4'd1;
                end
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

>>> rtl/core/trd_store.sv
// depth and fragment memory, one write and one registered read port
`timescale 1ns / 1ps
module trd_store
    import trd_pkg::*;
#(
    parameter int SIZE = DEF_MAX_WIDTH * DEF_MAX_HEIGHT,
    parameter int AW   = $clog2(SIZE)
) (
    input  logic           aclk,
    input  logic           wr_en,
    input  logic [AW-1:0]  wr_addr,
    input  logic [STW-1:0] wr_data,
    input  logic           rd_en,
    input  logic [AW-1:0]  rd_addr,
    output logic [STW-1:0] rd_data
);

    logic [STW-1:0] mem [0:SIZE-1];
    logic [STW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> bench/tb_triangle_raster_depth_test.sv
// testbench for triangle_raster_depth_test: random and directed items checked against a scoreboard
`timescale 1ns / 1ps
module tb_triangle_raster_depth_test;
    import trd_pkg::*;

    localparam int  STORE_WORDS = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
    localparam int  CYCLE_LIMIT = 40_000_000;
    localparam int  RAND_PER_PHASE = 170;

    typedef struct {
        logic [1:0]         op;
        logic [15:0]        tri_idx;
        logic signed [15:0] vx [3];
        logic signed [15:0] vy [3];
        logic [15:0]        vz [3];
        logic [13:0]        addr;
    } raster_item_t;

    typedef struct {
        logic [15:0] frag_tri;
        logic [15:0] w0;
        logic [15:0] w1;
        logic [15:0] w2;
        logic [15:0] depth;
        logic        covered;
    } pixel_word_t;

    class raster_scoreboard;
        bit [15:0]   depth_mem [STORE_WORDS];
        bit [63:0]   frag_mem [STORE_WORDS];
        int          width;
        int          height;
        pixel_word_t pending [$];
        int          errors;

        function new();
            width = 128;
            height = 128;
            errors = 0;
            clear_mem();
        endfunction

        function void clear_mem();
            foreach (depth_mem[i]) begin
                depth_mem[i] = DEPTH_CLEAR;
                frag_mem[i] = FRAG_CLEAR;
            end
        endfunction

        function void write_reg(logic idx, logic [7:0] value);
            if (idx == REG_WIDTH) width = value;
            else height = value;
        endfunction

        static function longint half_plane(longint ax, longint ay, longint bx, longint by,
                                           longint px, longint py);
            return (bx - ax) * (py - ay) - (by - ay) * (px - ax);
        endfunction

        static function bit [15:0] quot16(logic [127:0] num, longint den);
            logic [127:0] q;
            q = num / 128'(unsigned'(den));
            return (q > 128'd65535) ? 16'hFFFF : q[15:0];
        endfunction

        function void rasterize(raster_item_t it);
            longint w, h, area, mnx, mxx, mny, mxy, x0, x1, y0, y1, sx, sy;
            longint e01, e12, e20;
            longint vx [3];
            longint vy [3];
            logic [127:0] num;
            bit [15:0] d;
            int a;
            w = width > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : width;
            h = height > DEF_MAX_HEIGHT ? DEF_MAX_HEIGHT : height;
            if (w == 0 || h == 0) return;
            for (int k = 0; k < 3; k++) begin
                vx[k] = (longint'(it.vx[k]) + 16384) * w;
                vy[k] = (longint'(it.vy[k]) + 16384) * h;
            end
            area = half_plane(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2]);
            if (area <= 0) return;
            mnx = vx[0]; mxx = vx[0]; mny = vy[0]; mxy = vy[0];
            for (int k = 1; k < 3; k++) begin
                if (vx[k] < mnx) mnx = vx[k];
                if (vx[k] > mxx) mxx = vx[k];
                if (vy[k] < mny) mny = vy[k];
                if (vy[k] > mxy) mxy = vy[k];
            end
            if (mxx < 0 || mxy < 0) return;
            x0 = mnx < 0 ? 0 : mnx / 32768;
            y0 = mny < 0 ? 0 : mny / 32768;
            x1 = mxx / 32768; if (x1 > w - 1) x1 = w - 1;
            y1 = mxy / 32768; if (y1 > h - 1) y1 = h - 1;
            for (longint py = y0; py <= y1; py++) begin
                for (longint px = x0; px <= x1; px++) begin
                    sx = px * 32768;
                    sy = py * 32768;
                    e01 = half_plane(vx[0], vy[0], vx[1], vy[1], sx, sy);
                    e12 = half_plane(vx[1], vy[1], vx[2], vy[2], sx, sy);
                    e20 = half_plane(vx[2], vy[2], vx[0], vy[0], sx, sy);
                    if (e01 < 0 || e12 < 0 || e20 < 0) continue;
                    a = int'(py * w + px);
                    num = 128'(unsigned'(e12)) * it.vz[0] + 128'(unsigned'(e20)) * it.vz[1]
                        + 128'(unsigned'(e01)) * it.vz[2];
                    d = quot16(num, area);
                    if (depth_mem[a] > d) continue;
                    depth_mem[a] = d;
                    frag_mem[a] = {it.tri_idx,
                                   quot16(128'(unsigned'(e12)) * 65535, area),
                                   quot16(128'(unsigned'(e20)) * 65535, area),
                                   quot16(128'(unsigned'(e01)) * 65535, area)};
                end
            end
        endfunction

        function void note_input(raster_item_t it);
            pixel_word_t r;
            bit [63:0] f;
            case (it.op)
                OP_DRAW:  rasterize(it);
                OP_CLEAR: clear_mem();
                OP_READ: begin
                    f = frag_mem[it.addr];
                    r.frag_tri = f[63:48];
                    r.w0 = f[47:32];
                    r.w1 = f[31:16];
                    r.w2 = f[15:0];
                    r.depth = depth_mem[it.addr];
                    r.covered = (f[63:48] != TRI_NONE);
                    pending.push_back(r);
                end
                default: ;
            endcase
        endfunction

        function void check_result(pixel_word_t got);
            pixel_word_t want;
            logic [15:0] wv [6];
            logic [15:0] gv [6];
            string names [6];
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word, tri %0d", got.frag_tri);
                return;
            end
            want = pending.pop_front();
            names = '{"frag_tri", "weight_v0", "weight_v1", "weight_v2", "pixel_depth",
                      "covered"};
            wv = '{want.frag_tri, want.w0, want.w1, want.w2, want.depth, 16'(want.covered)};
            gv = '{got.frag_tri, got.w0, got.w1, got.w2, got.depth, 16'(got.covered)};
            for (int i = 0; i < 6; i++) begin
                if (wv[i] !== gv[i]) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch %s: expected %0d got %0d", names[i], wv[i], gv[i]);
                end
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = REG_WIDTH;
    logic [DIMW-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_op = OP_READ;
    logic [15:0] s_tri_index = '0;
    logic signed [15:0] s_vert0_x = '0, s_vert0_y = '0, s_vert1_x = '0, s_vert1_y = '0;
    logic signed [15:0] s_vert2_x = '0, s_vert2_y = '0;
    logic [15:0] s_vert0_invz = '0, s_vert1_invz = '0, s_vert2_invz = '0;
    logic [13:0] s_pixel_addr = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [15:0] m_frag_tri, m_weight_v0, m_weight_v1, m_weight_v2, m_pixel_depth;
    logic m_covered;

    raster_scoreboard sb = new();
    int send_idle = 0;
    int recv_idle = 0;
    int in_count = 0;
    int cfg_count = 0;
    int cur_w = 128;
    int cur_h = 128;
    longint cycles = 0;

    triangle_raster_depth_test dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        raster_item_t it;
        pixel_word_t r;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
        if (aresetn && cfg_valid && cfg_ready) begin
            sb.write_reg(cfg_index, cfg_data);
            cfg_count++;
        end
        if (aresetn && s_valid && s_ready) begin
            it.op = s_op;
            it.tri_idx = s_tri_index;
            it.vx = '{s_vert0_x, s_vert1_x, s_vert2_x};
            it.vy = '{s_vert0_y, s_vert1_y, s_vert2_y};
            it.vz = '{s_vert0_invz, s_vert1_invz, s_vert2_invz};
            it.addr = s_pixel_addr;
            sb.note_input(it);
            in_count++;
        end
        if (aresetn && m_valid && m_ready) begin
            r = '{m_frag_tri, m_weight_v0, m_weight_v1, m_weight_v2, m_pixel_depth, m_covered};
            sb.check_result(r);
        end
    end

    always @(negedge aclk) m_ready <= ($urandom_range(99) >= recv_idle);

    task automatic send_item(raster_item_t it);
        int start;
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        start = in_count;
        s_valid <= 1'b1;
        s_op <= it.op;
        s_tri_index <= it.tri_idx;
        {s_vert0_x, s_vert1_x, s_vert2_x} <= {it.vx[0], it.vx[1], it.vx[2]};
        {s_vert0_y, s_vert1_y, s_vert2_y} <= {it.vy[0], it.vy[1], it.vy[2]};
        {s_vert0_invz, s_vert1_invz, s_vert2_invz} <= {it.vz[0], it.vz[1], it.vz[2]};
        s_pixel_addr <= it.addr;
        do @(negedge aclk); while (in_count == start);
    endtask

    task automatic write_reg(logic idx, logic [7:0] value);
        int start;
        start = cfg_count;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(negedge aclk); while (cfg_count == start);
        cfg_valid <= 1'b0;
    endtask

    function automatic raster_item_t plain_item(logic [1:0] op, logic [13:0] addr);
        raster_item_t it;
        it.op = op;
        it.tri_idx = 16'($urandom);
        for (int k = 0; k < 3; k++) begin
            it.vx[k] = 16'($urandom);
            it.vy[k] = 16'($urandom);
            it.vz[k] = 16'($urandom);
        end
        it.addr = addr;
        return it;
    endfunction

    function automatic raster_item_t tri_item(logic [15:0] idx, int ax, int ay, int bx, int by,
                                              int cx, int cy, logic [15:0] z);
        raster_item_t it;
        it = plain_item(OP_DRAW, 14'($urandom));
        it.tri_idx = idx;
        it.vx = '{16'(ax), 16'(bx), 16'(cx)};
        it.vy = '{16'(ay), 16'(by), 16'(cy)};
        it.vz = '{z, z, z};
        return it;
    endfunction

    function automatic logic signed [15:0] clamp_ndc(int v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return 16'(v);
    endfunction

    function automatic raster_item_t random_item();
        raster_item_t it;
        int sel, we, he, spx, spy, cx, cy;
        logic signed [15:0] t;
        longint ar;
        sel = $urandom_range(99);
        we = cur_w > 128 ? 128 : cur_w;
        he = cur_h > 128 ? 128 : cur_h;
        if (sel < 1) return plain_item(OP_CLEAR, 14'($urandom));
        if (sel < 3) return plain_item(2'd3, 14'($urandom));
        if (sel < 40)
            return plain_item(OP_READ, ($urandom_range(99) < 75) ?
                              14'($urandom_range(0, we * he - 1)) : 14'($urandom));
        it = plain_item(OP_DRAW, 14'($urandom));
        // keep the bounding box a few pixels wide, on tiny screens only seven times in ten
        if (we * he > 64 || $urandom_range(9) < 7) begin
            spx = 3 * 32768 / we;
            spy = 3 * 32768 / he;
            cx = ($urandom_range(9) == 0) ? int'($urandom_range(0, 65535)) - 32768
                                          : int'($urandom_range(0, 32767)) - 16384;
            cy = ($urandom_range(9) == 0) ? int'($urandom_range(0, 65535)) - 32768
                                          : int'($urandom_range(0, 32767)) - 16384;
            for (int k = 0; k < 3; k++) begin
                it.vx[k] = clamp_ndc(cx + int'($urandom_range(0, 2 * spx)) - spx);
                it.vy[k] = clamp_ndc(cy + int'($urandom_range(0, 2 * spy)) - spy);
            end
        end
        ar = (longint'(it.vx[1]) - it.vx[0]) * (longint'(it.vy[2]) - it.vy[0])
           - (longint'(it.vy[1]) - it.vy[0]) * (longint'(it.vx[2]) - it.vx[0]);
        // mostly counter-clockwise so pixels actually get written
        if (ar < 0 && $urandom_range(99) < 85) begin
            t = it.vx[1]; it.vx[1] = it.vx[2]; it.vx[2] = t;
            t = it.vy[1]; it.vy[1] = it.vy[2]; it.vy[2] = t;
        end
        return it;
    endfunction

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    initial begin
        int dims [6][2];
        dims = '{'{8, 8}, '{1, 1}, '{128, 128}, '{1, 128}, '{128, 1}, '{13, 6}};
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        for (int p = 0; p < 6; p++) begin
            cur_w = dims[p][0];
            cur_h = dims[p][1];
            write_reg(REG_WIDTH, 8'(cur_w));
            write_reg(REG_HEIGHT, 8'(cur_h));
            send_idle = 0;
            recv_idle = 0;
            if (p == 0) begin
                send_item(plain_item(OP_READ, 14'd0));
                send_item(tri_item(16'd0, -32768, -32768, 32767, -32768, -32768, 32767,
                                   16'hFFFF));
                send_item(plain_item(OP_READ, 14'd0));
                send_item(plain_item(OP_READ, 14'd63));
                // clockwise and zero area draw nothing
                send_item(tri_item(16'd5, -32768, -32768, -32768, 32767, 32767, -32768,
                                   16'hFFFF));
                send_item(tri_item(16'd6, -16384, -16384, 0, 0, 16384, 16384, 16'hFFFF));
                send_item(tri_item(16'hFFFF, -16384, -16384, 16383, -16384, -16384, 16383,
                                   16'hFFFF));
                send_item(plain_item(OP_READ, 14'd9));
                send_item(plain_item(2'd3, 14'd1));
                send_item(tri_item(16'd7, -32768, -32768, 32767, -32768, -32768, 32767,
                                   16'h0000));
                send_item(plain_item(OP_READ, 14'd18));
                send_item(plain_item(OP_READ, 14'h3FFF));
                send_item(plain_item(OP_CLEAR, 14'd0));
                send_item(plain_item(OP_READ, 14'd0));
                send_item(tri_item(16'd8, -32768, -32768, -32000, -32768, -32768, -32000,
                                   16'h1234));
                send_item(tri_item(16'd9, 0, 0, 32767, 0, 0, 32767, 16'h8000));
                send_item(plain_item(OP_READ, 14'd36));
                send_item(plain_item(OP_READ, 14'd0));
            end
            for (int i = 0; i < RAND_PER_PHASE; i++) begin
                case (i * 3 / RAND_PER_PHASE)
                    0: begin send_idle = 33; recv_idle = 82; end
                    1: begin send_idle = 82; recv_idle = 33; end
                    default: begin send_idle = 0; recv_idle = 0; end
                endcase
                send_item(random_item());
            end
            // a read behind the last draw proves the block is idle again
            send_item(plain_item(OP_READ, 14'd0));
            wait_drained();
        end
        repeat (100) @(negedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
